[hw/rtl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the periodic task tick scheduler
// Opcodes, result kinds, slot record layout and sequencer states.
// ----------------------------------------------------------------------------
package pts_pkg;

    // Command opcodes
    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_DELETE   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_DISPATCH = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_ADDED   = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_DELETED = 3'd2;
    localparam logic [2:0] KIND_EMPTY   = 3'd3;
    localparam logic [2:0] KIND_RUN     = 3'd4;
    localparam logic [2:0] KIND_IDLE    = 3'd5;

    localparam int          TICKS_W     = 21;
    localparam int          MS_W        = 24;
    localparam logic [7:0]  PENDING_MAX = 8'hFF;
    localparam int          MAX_RESULTS = 16;
    localparam int          RUN_CNT_W   = $clog2(MAX_RESULTS + 1);

    // floor(x / 10) = (x * DIV10_MULT) >> DIV10_SHIFT, exact for x below 2**24
    localparam logic [MS_W-1:0] DIV10_MULT  = 24'hCCCCCD;
    localparam int              DIV10_SHIFT = 27;

    typedef struct packed {
        logic [7:0]         tag;
        logic [TICKS_W-1:0] countdown;
        logic [TICKS_W-1:0] period;
        logic [7:0]         pending;
    } t_slot_entry;

    typedef struct packed {
        logic        wr;
        logic        due;
        logic        free;
        t_slot_entry entry;
    } t_slot_upd;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] slot;
        logic [7:0] tag;
        logic       last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_DLY,
        S_DIV_PER,
        S_FIND,
        S_SCAN,
        S_EMIT
    } t_state;

endpackage

[hw/rtl/pts_if.sv]
// ----------------------------------------------------------------------------
// pts_if: command and result channels of the task scheduler
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pts_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  task_tag;
    logic [23:0] delay_ms;
    logic [23:0] period_ms;
    logic [3:0]  slot_index;

    modport source (output valid, opcode, task_tag, delay_ms, period_ms, slot_index,
                    input ready);
    modport sink   (input valid, opcode, task_tag, delay_ms, period_ms, slot_index,
                    output ready);
endinterface

interface pts_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] result_kind;
    logic [3:0] slot;
    logic [7:0] tag_out;
    logic       last;

    modport source (output valid, result_kind, slot, tag_out, last, input ready);
    modport sink   (input valid, result_kind, slot, tag_out, last, output ready);
endinterface

[hw/rtl/pts_ram.sv]
// ----------------------------------------------------------------------------
// pts_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[hw/rtl/pts_div10.sv]
// ----------------------------------------------------------------------------
// pts_div10: millisecond to tick converter
// Divides a 24-bit value by ten with a reciprocal multiply; registered result.
// ----------------------------------------------------------------------------
module pts_div10 (
    input  logic                        i_clk,
    input  logic [pts_pkg::MS_W-1:0]    i_x,
    output logic [pts_pkg::TICKS_W-1:0] o_q
);
    logic [2*pts_pkg::MS_W-1:0] w_prod;
    logic [pts_pkg::TICKS_W-1:0] r_q;

    assign w_prod = (2*pts_pkg::MS_W)'(i_x) * (2*pts_pkg::MS_W)'(pts_pkg::DIV10_MULT);

    always_ff @(posedge i_clk) begin
        r_q <= w_prod[pts_pkg::DIV10_SHIFT +: pts_pkg::TICKS_W];
    end

    assign o_q = r_q;
endmodule

[hw/rtl/pts_slot_alu.sv]
// ----------------------------------------------------------------------------
// pts_slot_alu: per-slot update for tick and dispatch
// Computes the new slot record and whether the slot runs or is freed.
// ----------------------------------------------------------------------------
module pts_slot_alu (
    input  logic [1:0]           i_op,
    input  logic                 i_slot_valid,
    input  logic                 i_runs_ok,
    input  pts_pkg::t_slot_entry i_entry,
    output pts_pkg::t_slot_upd   o_upd
);
    always_comb begin
        o_upd       = '0;
        o_upd.entry = i_entry;
        if (i_op == pts_pkg::OP_TICK) begin
            o_upd.wr = i_slot_valid;
            if (i_entry.countdown != '0) begin
                o_upd.entry.countdown = i_entry.countdown - 1'b1;
            end else begin
                o_upd.entry.countdown = i_entry.period;
                if (i_entry.pending != pts_pkg::PENDING_MAX) begin
                    o_upd.entry.pending = i_entry.pending + 1'b1;
                end
            end
        end else begin
            o_upd.due = i_slot_valid && (i_entry.pending != '0) && i_runs_ok;
            o_upd.wr  = o_upd.due;
            // one-shot tasks leave the table once they run
            o_upd.free = o_upd.due && (i_entry.period == '0);
            o_upd.entry.pending = i_entry.pending - 1'b1;
        end
    end
endmodule

[hw/rtl/periodic_task_tick_scheduler_top.sv]
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top: cooperative time-triggered task scheduler
// Slot table with add, delete, tick and dispatch commands.
// ----------------------------------------------------------------------------
// The block takes one command at a time and drops ready until it is done with
// it: until its last result is loaded into the output register, or for a tick,
// which gives no result, until the table walk ends. A delete is decided in the
// accept cycle. An add runs the delay and then the period through the shared
// divide-by-ten multiplier and then searches upward from slot 0 for the lowest
// free slot. Tick and dispatch walk the slot records, which live in one RAM
// with registered read, one slot per cycle; a dispatch pauses the walk while a
// run item waits on the consumer, and every final result waits for the output
// register to be free. Valid bits are flip-flops cleared by reset, so no
// clearing pass is needed.
module periodic_task_tick_scheduler_top #(
    parameter int NUM_SLOTS = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    pts_cmd_if.sink   i_cmd,
    pts_res_if.source o_res
);
    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int EW = $bits(pts_pkg::t_slot_entry);

    pts_pkg::t_state  r_state, n_state;
    logic [1:0]       r_op, n_op;
    logic [7:0]       r_tag, n_tag;
    logic [23:0]      r_dly, n_dly;
    logic [23:0]      r_per, n_per;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [pts_pkg::TICKS_W-1:0] r_dly_ticks, n_dly_ticks;
    logic [IW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_p_vld, n_p_vld;
    logic [IW-1:0]    r_p_idx, n_p_idx;
    logic             r_have, n_have;
    logic [3:0]       r_hold_slot, n_hold_slot;
    logic [7:0]       r_hold_tag, n_hold_tag;
    logic [pts_pkg::RUN_CNT_W-1:0] r_nrun, n_nrun;
    pts_pkg::t_result r_res, n_res;
    logic             r_out_vld, n_out_vld;
    pts_pkg::t_result r_out, n_out;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic             ram_re;
    logic [EW-1:0]    ram_rdata;
    logic [23:0]      w_div_x;
    logic [pts_pkg::TICKS_W-1:0] w_q;
    pts_pkg::t_slot_entry w_entry;
    pts_pkg::t_slot_entry w_new_entry;
    pts_pkg::t_slot_upd   w_upd;
    logic             w_out_free;
    logic             w_issue;
    logic             w_stall;
    logic             w_del_hit;
    logic [IW-1:0]    w_del_idx;

    pts_ram #(.WIDTH(EW), .DEPTH(NUM_SLOTS)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_rd_idx[IW-1:0]),
        .o_rd_data (ram_rdata)
    );

    assign w_div_x = (r_state == pts_pkg::S_DIV_DLY) ? r_dly : r_per;

    pts_div10 u_div10 (
        .i_clk (i_clk),
        .i_x   (w_div_x),
        .o_q   (w_q)
    );

    assign w_entry = pts_pkg::t_slot_entry'(ram_rdata);

    pts_slot_alu u_alu (
        .i_op         (r_op),
        .i_slot_valid (r_valid[r_p_idx]),
        .i_runs_ok    (r_nrun < pts_pkg::RUN_CNT_W'(pts_pkg::MAX_RESULTS)),
        .i_entry      (w_entry),
        .o_upd        (w_upd)
    );

    assign w_out_free = !r_out_vld || o_res.ready;
    assign w_issue    = r_rd_idx < CW'(NUM_SLOTS);
    assign w_stall    = r_p_vld && w_upd.due && r_have && !w_out_free;
    assign w_del_idx  = IW'(i_cmd.slot_index);
    assign w_del_hit  = (32'(i_cmd.slot_index) < 32'(NUM_SLOTS)) && r_valid[w_del_idx];

    always_comb begin
        w_new_entry.tag       = r_tag;
        w_new_entry.countdown = r_dly_ticks;
        w_new_entry.period    = w_q;
        w_new_entry.pending   = '0;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_tag       = r_tag;
        n_dly       = r_dly;
        n_per       = r_per;
        n_valid     = r_valid;
        n_dly_ticks = r_dly_ticks;
        n_idx       = r_idx;
        n_rd_idx    = r_rd_idx;
        n_p_vld     = r_p_vld;
        n_p_idx     = r_p_idx;
        n_have      = r_have;
        n_hold_slot = r_hold_slot;
        n_hold_tag  = r_hold_tag;
        n_nrun      = r_nrun;
        n_res       = r_res;
        n_out_vld   = r_out_vld && !o_res.ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_p_idx;
        ram_wdata   = w_upd.entry;
        ram_re      = 1'b0;

        case (r_state)
            pts_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op     = i_cmd.opcode;
                    n_tag    = i_cmd.task_tag;
                    n_dly    = i_cmd.delay_ms;
                    n_per    = i_cmd.period_ms;
                    n_have   = 1'b0;
                    n_nrun   = '0;
                    n_rd_idx = '0;
                    n_p_vld  = 1'b0;
                    case (i_cmd.opcode)
                        pts_pkg::OP_ADD: begin
                            n_state = pts_pkg::S_DIV_DLY;
                        end
                        pts_pkg::OP_DELETE: begin
                            n_res.slot = i_cmd.slot_index;
                            n_res.tag  = '0;
                            n_res.last = 1'b1;
                            if (w_del_hit) begin
                                n_valid[w_del_idx] = 1'b0;
                                n_res.kind = pts_pkg::KIND_DELETED;
                            end else begin
                                n_res.kind = pts_pkg::KIND_EMPTY;
                            end
                            n_state = pts_pkg::S_EMIT;
                        end
                        default: begin
                            n_state = pts_pkg::S_SCAN;
                        end
                    endcase
                end
            end

            pts_pkg::S_DIV_DLY: begin
                n_state = pts_pkg::S_DIV_PER;
            end

            pts_pkg::S_DIV_PER: begin
                // divider output now holds the delay in ticks
                n_dly_ticks = w_q;
                n_idx       = '0;
                n_state     = pts_pkg::S_FIND;
            end

            pts_pkg::S_FIND: begin
                n_res.tag  = '0;
                n_res.last = 1'b1;
                if (!r_valid[r_idx]) begin
                    ram_we         = 1'b1;
                    ram_waddr      = r_idx;
                    ram_wdata      = w_new_entry;
                    n_valid[r_idx] = 1'b1;
                    n_res.kind     = pts_pkg::KIND_ADDED;
                    n_res.slot     = 4'(r_idx);
                    n_state        = pts_pkg::S_EMIT;
                end else if (r_idx == IW'(NUM_SLOTS - 1)) begin
                    n_res.kind = pts_pkg::KIND_FULL;
                    n_res.slot = '0;
                    n_state    = pts_pkg::S_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            pts_pkg::S_SCAN: begin
                if (!w_stall) begin
                    if (r_p_vld) begin
                        ram_we = w_upd.wr;
                        if (w_upd.free) begin
                            n_valid[r_p_idx] = 1'b0;
                        end
                        if (w_upd.due) begin
                            // release the previously held run, hold this one
                            if (r_have) begin
                                n_out_vld = 1'b1;
                                n_out     = '{kind: pts_pkg::KIND_RUN, slot: r_hold_slot,
                                              tag: r_hold_tag, last: 1'b0};
                            end
                            n_have      = 1'b1;
                            n_hold_slot = 4'(r_p_idx);
                            n_hold_tag  = w_entry.tag;
                            n_nrun      = r_nrun + 1'b1;
                        end
                    end
                    if (w_issue) begin
                        ram_re   = 1'b1;
                        n_rd_idx = r_rd_idx + 1'b1;
                        n_p_vld  = 1'b1;
                        n_p_idx  = r_rd_idx[IW-1:0];
                    end else begin
                        n_p_vld = 1'b0;
                    end
                    if (!w_issue && !r_p_vld) begin
                        if (r_op == pts_pkg::OP_TICK) begin
                            n_state = pts_pkg::S_IDLE;
                        end else begin
                            if (r_have) begin
                                n_res = '{kind: pts_pkg::KIND_RUN, slot: r_hold_slot,
                                          tag: r_hold_tag, last: 1'b1};
                            end else begin
                                n_res = '{kind: pts_pkg::KIND_IDLE, slot: 4'd0,
                                          tag: 8'd0, last: 1'b1};
                            end
                            n_state = pts_pkg::S_EMIT;
                        end
                    end
                end
            end

            pts_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = pts_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = pts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pts_pkg::S_IDLE;
            r_valid   <= '0;
            r_p_vld   <= 1'b0;
            r_have    <= 1'b0;
            r_nrun    <= '0;
            r_rd_idx  <= '0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_p_vld   <= n_p_vld;
            r_have    <= n_have;
            r_nrun    <= n_nrun;
            r_rd_idx  <= n_rd_idx;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_tag       <= n_tag;
        r_dly       <= n_dly;
        r_per       <= n_per;
        r_dly_ticks <= n_dly_ticks;
        r_p_idx     <= n_p_idx;
        r_hold_slot <= n_hold_slot;
        r_hold_tag  <= n_hold_tag;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign i_cmd.ready       = (r_state == pts_pkg::S_IDLE);
    assign o_res.valid       = r_out_vld;
    assign o_res.result_kind = r_out.kind;
    assign o_res.slot        = r_out.slot;
    assign o_res.tag_out     = r_out.tag;
    assign o_res.last        = r_out.last;
endmodule

[hw/rtl/pts_checker.sv]
// ----------------------------------------------------------------------------
// pts_checker: port-level checks for the task scheduler
// Watches the command and result channels of the top level.
// ----------------------------------------------------------------------------
module pts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cmd_valid,
    input logic       i_cmd_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [2:0] i_res_kind,
    input logic [3:0] i_res_slot,
    input logic [7:0] i_res_tag,
    input logic       i_res_last
);
    // hold a stalled result item
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_kind) &&
            $stable(i_res_slot) && $stable(i_res_tag) && $stable(i_res_last)))
        else $error("result item changed while stalled");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)
        else $error("command taken while a previous one is in progress");

    // only run items may be followed by more results of the same command
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_kind != pts_pkg::KIND_RUN) |-> i_res_last)
        else $error("non-run result without last");

    // tag is returned only on run items
    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_kind != pts_pkg::KIND_RUN) |-> (i_res_tag == 8'd0))
        else $error("non-run result carries a tag");
endmodule

bind periodic_task_tick_scheduler_top pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.result_kind),
    .i_res_slot  (o_res.slot),
    .i_res_tag   (o_res.tag_out),
    .i_res_last  (o_res.last)
);

[bench/periodic_task_tick_scheduler_top_tb.sv]
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top_tb: self-checking bench of the task scheduler
// Drives add, delete, tick and dispatch commands over the command channel and
// checks each result item against a slot-table predictor kept in the bench or,
// on fixed directed rows, a typed-in result. Directed rows cover the empty table,
// extremes, the full table, one-shot release and repeated runs of a periodic
// task; random traffic follows under changing backpressure.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_top_tb;

    localparam int NUM_SLOTS    = 16;
    localparam int MS_PER_TICK  = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 4 * NUM_SLOTS;
    localparam int RAND_PER_PHASE = 57;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  tag;
        logic [23:0] dly_ms;
        logic [23:0] per_ms;
        logic [3:0]  idx;
    } t_cmd;

    typedef struct {
        t_cmd             c;
        int               reps;
        bit               fixed;
        pts_pkg::t_result res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    pts_cmd_if cmd_ch ();
    pts_res_if res_ch ();

    periodic_task_tick_scheduler_top #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch)
    );

    // Predicted slot table
    bit                          task_live   [NUM_SLOTS] = '{default: 1'b0};
    logic [7:0]                  task_tag_tbl[NUM_SLOTS];
    logic [pts_pkg::TICKS_W-1:0] task_left   [NUM_SLOTS];
    logic [pts_pkg::TICKS_W-1:0] task_period [NUM_SLOTS];
    logic [7:0]                  task_runs   [NUM_SLOTS];

    pts_pkg::t_result step_results[$];
    pts_pkg::t_result outcome_q[$];
    t_row             dir_rows[$];

    // Typed-in expectation that rides along with the item being offered
    bit               cur_fixed = 1'b0;
    pts_pkg::t_result cur_fixed_res;

    int  send_idle_pct = 34;
    int  recv_idle_pct = 75;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  err_count = 0;
    int  stall_cycles = 0;

    function automatic pts_pkg::t_result mk_result(logic [2:0] kind, logic [3:0] slot,
                                                   logic [7:0] tag, logic last);
        pts_pkg::t_result r;
        r.kind = kind;
        r.slot = slot;
        r.tag  = tag;
        r.last = last;
        return r;
    endfunction

    // Advance the slot table by one command; leave its result items in step_results
    function automatic void apply_command(input t_cmd c);
        bit placed;
        step_results.delete();
        case (c.op)
            pts_pkg::OP_ADD: begin
                placed = 1'b0;
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (!placed && !task_live[s]) begin
                        placed          = 1'b1;
                        task_live[s]    = 1'b1;
                        task_tag_tbl[s] = c.tag;
                        task_left[s]    = pts_pkg::TICKS_W'(c.dly_ms / MS_PER_TICK);
                        task_period[s]  = pts_pkg::TICKS_W'(c.per_ms / MS_PER_TICK);
                        task_runs[s]    = 8'd0;
                        step_results.push_back(mk_result(pts_pkg::KIND_ADDED, 4'(s),
                                                         8'd0, 1'b1));
                    end
                end
                if (!placed)
                    step_results.push_back(mk_result(pts_pkg::KIND_FULL, 4'd0, 8'd0, 1'b1));
            end
            pts_pkg::OP_DELETE: begin
                if (task_live[c.idx]) begin
                    task_live[c.idx] = 1'b0;
                    step_results.push_back(mk_result(pts_pkg::KIND_DELETED, c.idx,
                                                     8'd0, 1'b1));
                end else begin
                    step_results.push_back(mk_result(pts_pkg::KIND_EMPTY, c.idx,
                                                     8'd0, 1'b1));
                end
            end
            pts_pkg::OP_TICK: begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (task_live[s]) begin
                        if (task_left[s] != '0) begin
                            task_left[s] = task_left[s] - 1'b1;
                        end else begin
                            task_left[s] = task_period[s];
                            if (task_runs[s] != pts_pkg::PENDING_MAX)
                                task_runs[s] = task_runs[s] + 8'd1;
                        end
                    end
                end
            end
            default: begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (task_live[s] && task_runs[s] != 8'd0 &&
                        step_results.size() < pts_pkg::MAX_RESULTS) begin
                        task_runs[s] = task_runs[s] - 8'd1;
                        step_results.push_back(mk_result(pts_pkg::KIND_RUN, 4'(s),
                                                         task_tag_tbl[s], 1'b0));
                        // one-shot tasks give up their slot once run
                        if (task_period[s] == '0)
                            task_live[s] = 1'b0;
                    end
                end
                if (step_results.size() == 0)
                    step_results.push_back(mk_result(pts_pkg::KIND_IDLE, 4'd0, 8'd0, 1'b1));
                else
                    step_results[step_results.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic void dir_row(logic [1:0] op, logic [7:0] tag, logic [23:0] dly,
                                    logic [23:0] per, logic [3:0] idx, int reps,
                                    bit fixed, logic [2:0] kind, logic [3:0] slot);
        t_row r;
        r.c.op     = op;
        r.c.tag    = tag;
        r.c.dly_ms = dly;
        r.c.per_ms = per;
        r.c.idx    = idx;
        r.reps     = reps;
        r.fixed    = fixed;
        r.res      = mk_result(kind, slot, 8'd0, 1'b1);
        dir_rows.push_back(r);
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   pick;
        pick     = $urandom_range(99);
        c.op     = (pick < 30) ? pts_pkg::OP_ADD : (pick < 45) ? pts_pkg::OP_DELETE :
                   (pick < 75) ? pts_pkg::OP_TICK : pts_pkg::OP_DISPATCH;
        c.tag    = 8'($urandom_range(255));
        c.idx    = 4'($urandom_range(15));
        // mostly short delays and periods so tasks come due within a few ticks
        c.dly_ms = ($urandom_range(99) < 80) ? 24'($urandom_range(60)) : 24'($urandom);
        pick     = $urandom_range(99);
        c.per_ms = (pick < 15) ? 24'($urandom_range(9)) :
                   (pick < 80) ? 24'($urandom_range(60, 10)) : 24'($urandom);
        return c;
    endfunction

    // Offer one item from a falling edge; return at the falling edge after acceptance
    task automatic send_cmd(input t_cmd c, input bit fixed, input pts_pkg::t_result fres);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid      = 1'b1;
        cmd_ch.opcode     = c.op;
        cmd_ch.task_tag   = c.tag;
        cmd_ch.delay_ms   = c.dly_ms;
        cmd_ch.period_ms  = c.per_ms;
        cmd_ch.slot_index = c.idx;
        cur_fixed         = fixed;
        cur_fixed_res     = fres;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done    = 1'b1;
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Predict on every accepted command, check every accepted result
    always @(posedge i_clk) begin
        t_cmd             seen;
        pts_pkg::t_result got;
        pts_pkg::t_result want;
        bit               moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
                moved       = 1'b1;
                seen.op     = cmd_ch.opcode;
                seen.tag    = cmd_ch.task_tag;
                seen.dly_ms = cmd_ch.delay_ms;
                seen.per_ms = cmd_ch.period_ms;
                seen.idx    = cmd_ch.slot_index;
                apply_command(seen);
                if (cur_fixed)
                    outcome_q.push_back(cur_fixed_res);
                else
                    foreach (step_results[k]) outcome_q.push_back(step_results[k]);
            end
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                moved = 1'b1;
                got   = mk_result(res_ch.result_kind, res_ch.slot, res_ch.tag_out,
                                  res_ch.last);
                if (outcome_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result: kind %0d slot %0d tag %02h last %0b",
                                 got.kind, got.slot, got.tag, got.last);
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch: expected kind %0d slot %0d tag %02h %s",
                                     want.kind, want.slot, want.tag,
                                     $sformatf("last %0b, got kind %0d slot %0d %s",
                                               want.last, got.kind, got.slot,
                                               $sformatf("tag %02h last %0b",
                                                         got.tag, got.last)));
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        pts_pkg::t_result no_res;
        no_res            = mk_result(pts_pkg::KIND_ADDED, 4'd0, 8'd0, 1'b0);
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = pts_pkg::OP_TICK;
        cmd_ch.task_tag   = 8'd0;
        cmd_ch.delay_ms   = 24'd0;
        cmd_ch.period_ms  = 24'd0;
        cmd_ch.slot_index = 4'd0;

        // opcode, tag, delay_ms, period_ms, idx, reps, fixed, kind, slot
        dir_row(pts_pkg::OP_DISPATCH, 8'h00, 24'd0, 24'd0, 4'd0, 1, 1,
                pts_pkg::KIND_IDLE, 4'd0);
        dir_row(pts_pkg::OP_DELETE, 8'h00, 24'd0, 24'd0, 4'd0, 1, 1,
                pts_pkg::KIND_EMPTY, 4'd0);
        dir_row(pts_pkg::OP_DELETE, 8'h00, 24'd0, 24'd0, 4'd15, 1, 1,
                pts_pkg::KIND_EMPTY, 4'd15);
        // one-shot due at the first tick
        dir_row(pts_pkg::OP_ADD, 8'hFF, 24'd0, 24'd0, 4'd0, 1, 1,
                pts_pkg::KIND_ADDED, 4'd0);
        dir_row(pts_pkg::OP_ADD, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 4'd15, 1, 1,
                pts_pkg::KIND_ADDED, 4'd1);
        // 9 ms truncates to zero ticks; 10 ms period is one tick
        dir_row(pts_pkg::OP_ADD, 8'hA5, 24'd9, 24'd10, 4'd0, 1, 1,
                pts_pkg::KIND_ADDED, 4'd2);
        dir_row(pts_pkg::OP_TICK, 8'h00, 24'd0, 24'd0, 4'd0, 1, 0,
                pts_pkg::KIND_ADDED, 4'd0);
        dir_row(pts_pkg::OP_DISPATCH, 8'h00, 24'd0, 24'd0, 4'd0, 1, 0,
                pts_pkg::KIND_ADDED, 4'd0);
        // fill every free slot with one-tick one-shots
        dir_row(pts_pkg::OP_ADD, 8'h3C, 24'd19, 24'd5, 4'd0, 14, 0,
                pts_pkg::KIND_ADDED, 4'd0);
        dir_row(pts_pkg::OP_ADD, 8'hC3, 24'd0, 24'd0, 4'd0, 1, 1,
                pts_pkg::KIND_FULL, 4'd0);
        dir_row(pts_pkg::OP_DELETE, 8'h00, 24'd0, 24'd0, 4'd1, 1, 1,
                pts_pkg::KIND_DELETED, 4'd1);
        dir_row(pts_pkg::OP_DELETE, 8'h00, 24'd0, 24'd0, 4'd1, 1, 1,
                pts_pkg::KIND_EMPTY, 4'd1);
        dir_row(pts_pkg::OP_ADD, 8'h81, 24'd10, 24'd20, 4'd0, 1, 1,
                pts_pkg::KIND_ADDED, 4'd1);
        dir_row(pts_pkg::OP_TICK, 8'h00, 24'd0, 24'd0, 4'd0, 3, 0,
                pts_pkg::KIND_ADDED, 4'd0);
        // sixteen run items in one dispatch
        dir_row(pts_pkg::OP_DISPATCH, 8'h00, 24'd0, 24'd0, 4'd0, 2, 0,
                pts_pkg::KIND_ADDED, 4'd0);
        // build up runs of the periodic slots, then drain them
        dir_row(pts_pkg::OP_TICK, 8'h00, 24'd0, 24'd0, 4'd0, 4, 0,
                pts_pkg::KIND_ADDED, 4'd0);
        dir_row(pts_pkg::OP_DISPATCH, 8'h00, 24'd0, 24'd0, 4'd0, 3, 0,
                pts_pkg::KIND_ADDED, 4'd0);
        dir_row(pts_pkg::OP_DELETE, 8'h00, 24'd0, 24'd0, 4'd2, 1, 1,
                pts_pkg::KIND_DELETED, 4'd2);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r])
            repeat (dir_rows[r].reps)
                send_cmd(dir_rows[r].c, dir_rows[r].fixed, dir_rows[r].res);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 75;
                recv_idle_pct = 34;
            end else if (phase == 2) begin
                // pause until the table has answered everything, then flood
                cmd_ch.valid = 1'b0;
                while (outcome_q.size() != 0)
                    @(negedge i_clk);
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req      = 1'b1;
            end
            repeat (RAND_PER_PHASE)
                send_cmd(rand_cmd(), 1'b0, no_res);
        end

        cmd_ch.valid = 1'b0;
        while (outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
